>>> src/istp_pkg.sv
// Shared constants and types for the integer set text parser.
`default_nettype none

package istp_pkg;

    localparam int MAX_ELEMENTS_DEF = 64;
    localparam int VALUE_BITS_DEF   = 32;
    localparam int CMDQ_DEPTH       = 4;
    localparam int OUT_VALUE_BITS   = 32;
    localparam int OUT_COUNT_BITS   = 7;
    localparam int TDATA_BITS       = 40;

    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    typedef enum logic [1:0] {
        KIND_NEW    = 2'd0,
        KIND_END    = 2'd1,
        KIND_SYNTAX = 2'd2,
        KIND_FULL   = 2'd3
    } t_kind;

    // Action that follows the (optional) token of a command.
    typedef enum logic [1:0] {
        OP_NONE = 2'd0,
        OP_END  = 2'd1,
        OP_DROP = 2'd2,
        OP_SYN  = 2'd3
    } t_op;

    typedef struct packed {
        logic tok;
        t_op  op;
    } t_cmd_ctl;

endpackage

`default_nettype wire

>>> src/istp_front.sv
// Byte classifier and token accumulator; emits commands to the back end.
`default_nettype none

module istp_front
    import istp_pkg::*;
#(
    parameter int VALUE_BITS = VALUE_BITS_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_valid,
    output logic                       o_ready,
    input  wire logic [7:0]            i_ch,
    input  wire logic                  i_eos,
    input  wire logic                  i_q_full,
    output logic                       o_push,
    output t_cmd_ctl                   o_ctl,
    output logic [VALUE_BITS-1:0]      o_value
);

    logic                  r_await, n_await;
    logic                  r_in_num, n_in_num;
    logic                  r_neg, n_neg;
    logic                  r_closed, n_closed;
    logic                  r_tok_open, n_tok_open;
    logic                  r_disc, n_disc;
    logic [VALUE_BITS-1:0] r_acc, n_acc;

    logic                  w_take;
    logic                  w_is_digit;
    logic [3:0]            w_digit;
    logic [VALUE_BITS-1:0] w_acc_next;

    assign o_ready    = !i_q_full;
    assign w_take     = i_valid && o_ready;
    assign w_is_digit = (i_ch >= CH_ZERO) && (i_ch <= CH_NINE);
    assign w_digit    = 4'(i_ch - CH_ZERO);
    assign w_acc_next = (r_acc << 3) + (r_acc << 1) + VALUE_BITS'(w_digit);
    assign o_value    = r_neg ? (VALUE_BITS'(0) - r_acc) : r_acc;

    always_comb begin
        n_await    = r_await;
        n_in_num   = r_in_num;
        n_neg      = r_neg;
        n_closed   = r_closed;
        n_tok_open = r_tok_open;
        n_disc     = r_disc;
        n_acc      = r_acc;
        o_push     = 1'b0;
        o_ctl      = '{tok: 1'b0, op: OP_NONE};
        if (w_take) begin
            priority if (r_await) begin
                n_in_num   = 1'b0;
                n_neg      = 1'b0;
                n_closed   = 1'b0;
                n_tok_open = 1'b0;
                n_acc      = '0;
                n_disc     = 1'b0;
                if (i_eos) begin
                    o_push    = 1'b1;
                    o_ctl.op  = OP_END;
                end else begin
                    n_await = 1'b0;
                end
            end else if (i_eos) begin
                o_push = 1'b1;
                if (!r_disc) begin
                    o_ctl.tok = r_tok_open;
                    o_ctl.op  = OP_END;
                end else begin
                    o_ctl.op  = OP_DROP;
                end
                n_in_num   = 1'b0;
                n_neg      = 1'b0;
                n_closed   = 1'b0;
                n_tok_open = 1'b0;
                n_acc      = '0;
                n_disc     = 1'b0;
                n_await    = 1'b1;
            end else if (!r_disc) begin
                if (i_ch == CH_COMMA) begin
                    if (r_tok_open) begin
                        o_push    = 1'b1;
                        o_ctl.tok = 1'b1;
                    end
                    n_in_num   = 1'b0;
                    n_neg      = 1'b0;
                    n_closed   = 1'b0;
                    n_tok_open = 1'b0;
                    n_acc      = '0;
                end else begin
                    n_tok_open = 1'b1;
                    priority if (i_ch == CH_SPACE) begin
                        if (r_in_num) begin
                            n_closed = 1'b1;
                        end
                    end else if ((i_ch == CH_MINUS) && !r_in_num) begin
                        n_in_num = 1'b1;
                        n_neg    = 1'b1;
                    end else if (w_is_digit && !r_closed) begin
                        n_in_num = 1'b1;
                        n_acc    = w_acc_next;
                    end else begin
                        o_push     = 1'b1;
                        o_ctl.op   = OP_SYN;
                        n_in_num   = 1'b0;
                        n_neg      = 1'b0;
                        n_closed   = 1'b0;
                        n_tok_open = 1'b0;
                        n_acc      = '0;
                        n_disc     = 1'b1;
                    end
                end
            end else begin
                // discarding: byte dropped
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_await    <= 1'b1;
            r_in_num   <= 1'b0;
            r_neg      <= 1'b0;
            r_closed   <= 1'b0;
            r_tok_open <= 1'b0;
            r_disc     <= 1'b0;
            r_acc      <= '0;
        end else begin
            r_await    <= n_await;
            r_in_num   <= n_in_num;
            r_neg      <= n_neg;
            r_closed   <= n_closed;
            r_tok_open <= n_tok_open;
            r_disc     <= n_disc;
            r_acc      <= n_acc;
        end
    end

endmodule

`default_nettype wire

>>> src/istp_fifo.sv
// Small show-ahead command queue between front and back end.
`default_nettype none

module istp_fifo
    import istp_pkg::*;
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = CMDQ_DEPTH
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_data,
    input  wire logic             i_pop,
    output logic [WIDTH-1:0]      o_data,
    output logic                  o_full,
    output logic                  o_empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wptr;
    logic [PW-1:0]    r_rptr;
    logic [CW-1:0]    r_cnt;
    logic             w_push;
    logic             w_pop;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rptr];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (w_push) begin
                r_wptr <= (r_wptr == PW'(DEPTH - 1)) ? '0 : PW'(r_wptr + 1'b1);
            end
            if (w_pop) begin
                r_rptr <= (r_rptr == PW'(DEPTH - 1)) ? '0 : PW'(r_rptr + 1'b1);
            end
            if (w_push && !w_pop) begin
                r_cnt <= CW'(r_cnt + 1'b1);
            end else if (w_pop && !w_push) begin
                r_cnt <= CW'(r_cnt - 1'b1);
            end
        end
    end

endmodule

`default_nettype wire

>>> src/istp_back.sv
// Duplicate search over the element store and result generation.
`default_nettype none

module istp_back
    import istp_pkg::*;
#(
    parameter int MAX_ELEMENTS = MAX_ELEMENTS_DEF,
    parameter int VALUE_BITS   = VALUE_BITS_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_q_empty,
    output logic                       o_pop,
    input  wire t_cmd_ctl              i_ctl,
    input  wire logic [VALUE_BITS-1:0] i_value,
    output logic                       o_valid,
    input  wire logic                  i_ready,
    output t_kind                      o_kind,
    output logic [OUT_VALUE_BITS-1:0]  o_value,
    output logic [OUT_COUNT_BITS-1:0]  o_count,
    output logic                       o_final
);

    localparam int CW = $clog2(MAX_ELEMENTS + 1);
    localparam int IW = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SRCH,
        ST_PUT,
        ST_OP
    } t_state;

    t_state                r_state;
    t_op                   r_op;
    logic [VALUE_BITS-1:0] r_val;
    logic [CW-1:0]         r_count;
    logic                  r_disc;
    logic [CW-1:0]         r_idx;
    logic                  r_cmp_v;
    logic [VALUE_BITS-1:0] r_rdata;
    logic [VALUE_BITS-1:0] r_store [MAX_ELEMENTS];

    logic w_slot;
    logic w_full;
    logic w_we;
    logic w_match;
    logic w_ends;
    logic w_emit;

    assign w_slot  = !o_valid || i_ready;
    assign w_full  = (r_count == CW'(MAX_ELEMENTS));
    assign w_we    = (r_state == ST_PUT) && w_slot && !w_full;
    assign w_match = r_cmp_v && (r_rdata == r_val);
    assign w_ends  = (r_op == OP_END) || (r_op == OP_DROP);
    assign w_emit  = w_slot && ((r_state == ST_PUT) ||
                     ((r_state == ST_OP) && ((r_op == OP_END) || (r_op == OP_SYN))));
    assign o_pop   = (r_state == ST_IDLE) && !i_q_empty;

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_store[r_count[IW-1:0]] <= r_val;
        end
        r_rdata <= r_store[r_idx[IW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_count <= '0;
            r_disc  <= 1'b0;
            r_idx   <= '0;
            r_cmp_v <= 1'b0;
            o_valid <= 1'b0;
        end else begin
            if (w_emit) begin
                o_valid <= 1'b1;
            end else if (i_ready) begin
                o_valid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (!i_q_empty) begin
                        r_op    <= i_ctl.op;
                        r_val   <= i_value;
                        r_idx   <= '0;
                        r_cmp_v <= 1'b0;
                        if (r_disc) begin
                            if ((i_ctl.op == OP_END) || (i_ctl.op == OP_DROP)) begin
                                r_count <= '0;
                                r_disc  <= 1'b0;
                            end
                        end else if (i_ctl.tok) begin
                            r_state <= ST_SRCH;
                        end else begin
                            r_state <= ST_OP;
                        end
                    end
                end
                ST_SRCH: begin
                    r_cmp_v <= (r_idx != r_count);
                    if (r_idx != r_count) begin
                        r_idx <= CW'(r_idx + 1'b1);
                    end
                    if (w_match) begin
                        r_state <= ST_OP;
                    end else if (!r_cmp_v && (r_idx == r_count)) begin
                        r_state <= ST_PUT;
                    end
                end
                ST_PUT: begin
                    if (w_slot) begin
                        if (w_full) begin
                            o_kind  <= KIND_FULL;
                            o_value <= '0;
                            o_count <= OUT_COUNT_BITS'(r_count);
                            o_final <= 1'b1;
                            if (w_ends) begin
                                r_count <= '0;
                                r_disc  <= 1'b0;
                            end else begin
                                r_disc  <= 1'b1;
                            end
                            r_state <= ST_IDLE;
                        end else begin
                            o_kind  <= KIND_NEW;
                            o_value <= OUT_VALUE_BITS'($signed(r_val));
                            o_count <= OUT_COUNT_BITS'(CW'(r_count + 1'b1));
                            o_final <= 1'b0;
                            r_count <= CW'(r_count + 1'b1);
                            r_state <= ST_OP;
                        end
                    end
                end
                ST_OP: begin
                    unique case (r_op)
                        OP_NONE: begin
                            r_state <= ST_IDLE;
                        end
                        OP_DROP: begin
                            r_count <= '0;
                            r_disc  <= 1'b0;
                            r_state <= ST_IDLE;
                        end
                        OP_END: begin
                            if (w_slot) begin
                                o_kind  <= KIND_END;
                                o_value <= '0;
                                o_count <= OUT_COUNT_BITS'(r_count);
                                o_final <= 1'b1;
                                r_count <= '0;
                                r_state <= ST_IDLE;
                            end
                        end
                        OP_SYN: begin
                            if (w_slot) begin
                                o_kind  <= KIND_SYNTAX;
                                o_value <= '0;
                                o_count <= OUT_COUNT_BITS'(r_count);
                                o_final <= 1'b1;
                                r_disc  <= 1'b1;
                                r_state <= ST_IDLE;
                            end
                        end
                        default: begin
                            r_state <= ST_IDLE;
                        end
                    endcase
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

>>> src/integer_set_text_parser.sv
// Top level of the integer set text parser.
//
// Input stream: one text byte of a set literal such as {3, -1,3} per
// transaction, tlast on the final byte. The first and the final byte of a
// literal are dropped; tokens between commas are parsed as signed decimals.
// Output stream: one result per transaction, kind on tuser (new element,
// end of set, syntax error, store full), value and count on tdata, tlast on
// the last result of a literal.
// Bytes are taken at one per cycle into a four-entry command queue; tready
// drops only while that queue is full. For each completed token the back
// end's duplicate search reads the element store one entry per cycle
// through its registered read port.
// Reset clears all control state; the element store needs no clearing
// pass, since only entries below the element count are ever compared.
// When the receiver stalls, the output register holds its result, the back
// end waits, the queue fills and the input side then back-pressures.
`default_nettype none

module integer_set_text_parser
    import istp_pkg::*;
#(
    parameter int MAX_ELEMENTS = MAX_ELEMENTS_DEF,
    parameter int VALUE_BITS   = VALUE_BITS_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_s_axis_tvalid,
    output logic                       o_s_axis_tready,
    input  wire logic [7:0]            i_s_axis_tdata,   // [7:0] ch
    input  wire logic                  i_s_axis_tlast,
    output logic                       o_m_axis_tvalid,
    input  wire logic                  i_m_axis_tready,
    output logic [TDATA_BITS-1:0]      o_m_axis_tdata,   // [31:0] value, [38:32] count
    output logic [1:0]                 o_m_axis_tuser,   // [1:0] kind
    output logic                       o_m_axis_tlast
);

    localparam int QW = $bits(t_cmd_ctl) + VALUE_BITS;

    logic                      w_push;
    t_cmd_ctl                  w_push_ctl;
    logic [VALUE_BITS-1:0]     w_push_val;
    logic                      w_pop;
    logic [QW-1:0]             w_q_out;
    t_cmd_ctl                  w_pop_ctl;
    logic [VALUE_BITS-1:0]     w_pop_val;
    logic                      w_q_full;
    logic                      w_q_empty;
    t_kind                     w_kind;
    logic [OUT_VALUE_BITS-1:0] w_value;
    logic [OUT_COUNT_BITS-1:0] w_count;

    assign w_pop_ctl = w_q_out[QW-1 -: $bits(t_cmd_ctl)];
    assign w_pop_val = w_q_out[VALUE_BITS-1:0];

    istp_front #(
        .VALUE_BITS (VALUE_BITS)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_s_axis_tvalid),
        .o_ready  (o_s_axis_tready),
        .i_ch     (i_s_axis_tdata),
        .i_eos    (i_s_axis_tlast),
        .i_q_full (w_q_full),
        .o_push   (w_push),
        .o_ctl    (w_push_ctl),
        .o_value  (w_push_val)
    );

    istp_fifo #(
        .WIDTH (QW),
        .DEPTH (CMDQ_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  ({w_push_ctl, w_push_val}),
        .i_pop   (w_pop),
        .o_data  (w_q_out),
        .o_full  (w_q_full),
        .o_empty (w_q_empty)
    );

    istp_back #(
        .MAX_ELEMENTS (MAX_ELEMENTS),
        .VALUE_BITS   (VALUE_BITS)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_empty (w_q_empty),
        .o_pop     (w_pop),
        .i_ctl     (w_pop_ctl),
        .i_value   (w_pop_val),
        .o_valid   (o_m_axis_tvalid),
        .i_ready   (i_m_axis_tready),
        .o_kind    (w_kind),
        .o_value   (w_value),
        .o_count   (w_count),
        .o_final   (o_m_axis_tlast)
    );

    assign o_m_axis_tdata = {{(TDATA_BITS - OUT_COUNT_BITS - OUT_VALUE_BITS){1'b0}},
                             w_count, w_value};
    assign o_m_axis_tuser = w_kind;

endmodule

`default_nettype wire

>>> src/istp_chk.sv
// Port-level assertion checker for the integer set text parser, with bind.
`default_nettype none

module istp_chk
    import istp_pkg::*;
(
    input wire logic                  i_clk,
    input wire logic                  i_rst_n,
    input wire logic                  i_s_axis_tvalid,
    input wire logic                  o_s_axis_tready,
    input wire logic [7:0]            i_s_axis_tdata,
    input wire logic                  i_s_axis_tlast,
    input wire logic                  o_m_axis_tvalid,
    input wire logic                  i_m_axis_tready,
    input wire logic [TDATA_BITS-1:0] o_m_axis_tdata,
    input wire logic [1:0]            o_m_axis_tuser,
    input wire logic                  o_m_axis_tlast
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid)
        else $error("output transaction withdrawn while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser) && $stable(o_m_axis_tlast))
        else $error("output payload changed while stalled");

    a_value_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && (o_m_axis_tuser != KIND_NEW) |->
            (o_m_axis_tdata[OUT_VALUE_BITS-1:0] == '0))
        else $error("nonzero value on a non-element result");

    a_last_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (o_m_axis_tlast == (o_m_axis_tuser != KIND_NEW)))
        else $error("tlast does not match result kind");

endmodule

bind integer_set_text_parser istp_chk u_istp_chk (.*);

`default_nettype wire

>>> bench/integer_set_text_parser_tb.sv
// Self-checking testbench for the integer set text parser: set literals in, checked results out.
`default_nettype none

module integer_set_text_parser_tb;
    import istp_pkg::*;

    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int DRAIN_CYCLES = MAX_ELEMENTS_DEF + 40;
    localparam int TARGET_BYTES = 1500;

    typedef struct packed {
        t_kind       kind;
        logic [31:0] value;
        logic [6:0]  count;
        logic        fin;
    } set_result_t;

    class set_parse_scoreboard;
        bit          awaiting_open;
        bit          in_number;
        bit          negative;
        bit          number_closed;
        bit          token_open;
        bit          discarding;
        logic [31:0] acc;
        logic [31:0] elements[MAX_ELEMENTS_DEF];
        int          n_elements;
        set_result_t pending_results[$];
        int          errors;
        int          n_checked;
        int          kind_seen[4];

        function void reset();
            clear_string();
            awaiting_open = 1'b1;
            pending_results.delete();
        endfunction

        function void clear_token();
            in_number     = 1'b0;
            negative      = 1'b0;
            number_closed = 1'b0;
            token_open    = 1'b0;
            acc           = '0;
        endfunction

        function void clear_string();
            clear_token();
            discarding = 1'b0;
            n_elements = 0;
        endfunction

        function void push(t_kind k, logic [31:0] v, logic fin);
            set_result_t r;
            r.kind  = k;
            r.value = v;
            r.count = n_elements[6:0];
            r.fin   = fin;
            pending_results.push_back(r);
        endfunction

        function void close_token();
            logic [31:0] v;
            bit          dup;
            if (!token_open) return;
            v = negative ? (32'd0 - acc) : acc;
            clear_token();
            dup = 1'b0;
            for (int i = 0; i < n_elements; i++) begin
                if (elements[i] == v) dup = 1'b1;
            end
            if (dup) return;
            if (n_elements >= MAX_ELEMENTS_DEF) begin
                push(KIND_FULL, '0, 1'b1);
                discarding = 1'b1;
                return;
            end
            elements[n_elements] = v;
            n_elements++;
            push(KIND_NEW, v, 1'b0);
        endfunction

        function void take_byte(logic [7:0] ch, logic eos);
            if (awaiting_open) begin
                clear_string();
                awaiting_open = 1'b0;
                if (eos) begin
                    push(KIND_END, '0, 1'b1);
                    awaiting_open = 1'b1;
                end
                return;
            end
            if (eos) begin
                if (!discarding) begin
                    close_token();
                    if (!discarding) push(KIND_END, '0, 1'b1);
                end
                clear_string();
                awaiting_open = 1'b1;
                return;
            end
            if (discarding) return;
            if (ch == CH_COMMA) begin
                close_token();
                return;
            end
            token_open = 1'b1;
            if (ch == CH_SPACE) begin
                if (in_number) number_closed = 1'b1;
            end else if (ch == CH_MINUS && !in_number) begin
                in_number = 1'b1;
                negative  = 1'b1;
            end else if (ch >= CH_ZERO && ch <= CH_NINE && !number_closed) begin
                in_number = 1'b1;
                acc = acc * 32'd10 + {24'd0, ch - CH_ZERO};
            end else begin
                push(KIND_SYNTAX, '0, 1'b1);
                clear_token();
                discarding = 1'b1;
            end
        endfunction

        function void note_error(string msg);
            if (errors < 10) $display("MISMATCH: %s", msg);
            errors++;
        endfunction

        function void check_result(logic [1:0] kind, logic [TDATA_BITS-1:0] data, logic fin);
            set_result_t           e;
            logic [TDATA_BITS-1:0] exp_data;
            n_checked++;
            kind_seen[kind]++;
            if (pending_results.size() == 0) begin
                note_error($sformatf("unexpected result kind=%0d tdata=%h tlast=%b",
                                     kind, data, fin));
                return;
            end
            e = pending_results.pop_front();
            exp_data = {1'b0, e.count, e.value};
            if (kind !== e.kind || data !== exp_data || fin !== e.fin) begin
                note_error($sformatf("kind %0d/%0d value %h/%h count %0d/%0d tlast %b/%b (exp/act)",
                                     e.kind, kind, e.value, data[31:0],
                                     e.count, data[38:32], e.fin, fin));
            end
        endfunction
    endclass

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  s_valid;
    logic [7:0]            s_data;
    logic                  s_last;
    logic                  m_ready;
    logic                  o_s_axis_tready;
    logic                  o_m_axis_tvalid;
    logic [TDATA_BITS-1:0] o_m_axis_tdata;
    logic [1:0]            o_m_axis_tuser;
    logic                  o_m_axis_tlast;

    set_parse_scoreboard sb = new;
    logic [7:0]          txt[$];
    bit                  no_gap_run;
    int                  n_sent;
    int                  n_literals;
    int                  cycle_count;

    integer_set_text_parser dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (s_data),
        .i_s_axis_tlast  (s_last),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("integer_set_text_parser_tb: done, errors");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && m_ready)
            sb.check_result(o_m_axis_tuser, o_m_axis_tdata, o_m_axis_tlast);
    end

    initial begin
        int r;
        int len;
        bit level;
        m_ready = 1'b0;
        forever begin
            r = $urandom_range(0, 99);
            if (r < 20) begin
                len   = $urandom_range(20, 80);
                level = 1'b1;
            end else if (r < 88) begin
                len   = $urandom_range(1, 3);
                level = $urandom_range(0, 1);
            end else begin
                len   = $urandom_range(10, 40);
                level = 1'b0;
            end
            repeat (len) begin
                @(negedge i_clk);
                m_ready = level;
            end
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic void put(string s);
        for (int i = 0; i < s.len(); i++) txt.push_back(s[i]);
    endfunction

    function automatic void put_noise(int n);
        repeat (n) txt.push_back(8'($urandom_range(0, 255)));
    endfunction

    task automatic send_byte(input logic [7:0] c, input logic last);
        int gap;
        gap = no_gap_run ? 0 : pick_gap();
        repeat (gap) begin
            @(negedge i_clk);
            s_valid = 1'b0;
        end
        @(negedge i_clk);
        s_valid = 1'b1;
        s_data  = c;
        s_last  = last;
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        sb.take_byte(c, last);
        n_sent++;
    endtask

    task automatic send_literal();
        no_gap_run = ($urandom_range(0, 3) == 0);
        for (int i = 0; i < txt.size(); i++) send_byte(txt[i], i == txt.size() - 1);
        txt.delete();
        n_literals++;
    endtask

    function automatic string rand_token();
        string s;
        int    sel;
        s   = "";
        sel = $urandom_range(0, 11);
        case (sel)
            0, 1, 2: s = $sformatf("%0d", $urandom_range(0, 15));
            3: s = $sformatf("-%0d", $urandom_range(0, 15));
            4: s = $sformatf("%0d", $urandom());
            5: s = $sformatf("-%0d", $urandom());
            6: begin
                if ($urandom_range(0, 1)) s = "-";
                repeat ($urandom_range(10, 14)) s = $sformatf("%s%0d", s, $urandom_range(0, 9));
            end
            7: s = " ";
            8: s = "-";
            9: s = $sformatf("  %0d ", $urandom_range(0, 99));
            10: begin
                case ($urandom_range(0, 4))
                    0: s = "2147483647";
                    1: s = "-2147483648";
                    2: s = "4294967295";
                    3: s = "-0";
                    default: s = "0";
                endcase
            end
            default: s = $sformatf("%0d %0d", $urandom_range(0, 9), $urandom_range(0, 9));
        endcase
        return s;
    endfunction

    // fill the store to around its capacity with distinct values, at times plus one duplicate
    function automatic void build_fill_literal();
        int n;
        int base;
        case ($urandom_range(0, 3))
            0: n = MAX_ELEMENTS_DEF - 1;
            1: n = MAX_ELEMENTS_DEF;
            2: n = MAX_ELEMENTS_DEF + 1;
            default: n = MAX_ELEMENTS_DEF + 6;
        endcase
        base = $urandom_range(0, 1000) - 500;
        put("{");
        for (int i = 0; i < n; i++) begin
            if (i > 0) put(",");
            put($sformatf("%0d", base + i));
            if (i == n / 2 && $urandom_range(0, 1)) put($sformatf(",%0d", base));
        end
        put("}");
    endfunction

    function automatic void build_random_literal(bit force_fill);
        int sel;
        int ntok;
        sel = $urandom_range(0, 99);
        if (force_fill || sel < 4) begin
            build_fill_literal();
            return;
        end
        if (sel < 7) begin
            put_noise(1);
            return;
        end
        if ($urandom_range(0, 99) < 85) put("{");
        else put_noise(1);
        if (sel < 17) begin
            put_noise($urandom_range(1, 12));
        end else begin
            ntok = $urandom_range(0, 8);
            if ($urandom_range(0, 9) == 0) put(",");
            for (int t = 0; t < ntok; t++) begin
                if (t > 0) put(",");
                if ($urandom_range(0, 9) == 0) put(",");
                if ($urandom_range(0, 99) < 8) put_noise($urandom_range(1, 4));
                else put(rand_token());
            end
            if ($urandom_range(0, 9) == 0) put(",");
        end
        if ($urandom_range(0, 99) < 85) put("}");
        else put_noise(1);
    endfunction

    initial begin
        int n_random;
        i_rst_n  = 1'b0;
        s_valid  = 1'b0;
        s_data   = '0;
        s_last   = 1'b0;
        n_sent   = 0;
        n_literals  = 0;
        cycle_count = 0;
        n_random = 0;
        sb.reset();
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: duplicates and spaces, lone byte, blank and minus-only tokens,
        // closed number followed by a digit, NUL and non-ASCII bytes
        put("{3, -1,3}");
        send_literal();
        put("x");
        send_literal();
        put("{ ,-}");
        send_literal();
        put("{1 2}");
        send_literal();
        txt.push_back("{"); txt.push_back(8'h00); txt.push_back("}");
        send_literal();
        txt.push_back("{"); txt.push_back(8'hFF); txt.push_back("}");
        send_literal();

        while (n_sent < TARGET_BYTES) begin
            build_random_literal(n_random % 15 == 1);
            send_literal();
            n_random++;
        end
        @(negedge i_clk);
        s_valid = 1'b0;
        s_last  = 1'b0;

        while (sb.pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (sb.pending_results.size() != 0)
            sb.note_error($sformatf("%0d expected results never arrived",
                                    sb.pending_results.size()));
        $display("Sent %0d bytes in %0d literals; checked %0d results, %0d errors.",
                 n_sent, n_literals, sb.n_checked, sb.errors);
        $display("Results by kind: %0d new, %0d end, %0d syntax, %0d full.",
                 sb.kind_seen[0], sb.kind_seen[1], sb.kind_seen[2], sb.kind_seen[3]);
        if (sb.errors == 0) begin
            $display("integer_set_text_parser_tb: done, clean");
        end else begin
            $display("integer_set_text_parser_tb: done, errors");
        end
        $finish;
    end

endmodule

`default_nettype wire

>>> integer_set_text_parser.f
src/istp_pkg.sv
src/istp_front.sv
src/istp_fifo.sv
src/istp_back.sv
src/integer_set_text_parser.sv
src/istp_chk.sv
bench/integer_set_text_parser_tb.sv
